/* src/ubx_nav_frame_parser_top_defines.svh */
// Assertion macros for the frame parser datapath.
`ifndef UBX_NAV_FRAME_PARSER_TOP_DEFINES_SVH
`define UBX_NAV_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every clock edge outside reset.
`define UBXNAV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UBXNAV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UBXNAV_ASSERT(label, prop, msg)
`define UBXNAV_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* src/ubxnav_pkg.sv */
// Shared constants and controller/datapath interface types for the frame parser.
package ubxnav_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Configuration register indices
    localparam int         CFG_ADDR_W       = 2;
    localparam logic [1:0] CFG_WANTED_CLASS = 2'd0;
    localparam logic [1:0] CFG_WANTED_ID    = 2'd1;
    localparam logic [1:0] CFG_MIN_FIX      = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_WORD    = 2'd0;
    localparam logic [1:0] STAT_CKSUM   = 2'd1;
    localparam logic [1:0] STAT_FIX_LOW = 2'd2;

    localparam int TDATA_W = 72;
    localparam int TUSER_W = 3;

    typedef struct packed {
        logic       sum_init;
        logic       sum_add;
        logic       ld_class;
        logic       ld_id;
        logic       ld_len_lo;
        logic       ld_len_hi;
        logic       frame_start;
        logic       pay_byte;
        logic       ld_ck_a;
        logic       emit_status;
        logic [1:0] status;
        logic       rd_first;
        logic       rd_issue;
        logic       emit_word;
    } cmd_t;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic class_match;
        logic len_zero;
        logic pay_done;
        logic ck_ok;
        logic fix_ok;
        logic out_free;
        logic word_last;
    } sts_t;

endpackage

/* src/ubx_nav_frame_parser_top.sv */
// Top level of the UBX navigation frame parser.
// Receives one serial byte per s_ transfer, finds UBX frames (sync B5 62), checks the
// Fletcher-8 checksum and, for the configured class/id with a fix type at or above
// min_fix_type, sends the payload buffer as ceil(PAYLOAD_BYTES/8) little-endian 64-bit
// words on m_, the last one with tlast; a bad checksum or low fix gives one status
// transfer instead. While parsing, a byte is taken every cycle, except that the second
// checksum byte waits for a free result register. After that byte of a published frame
// the input is held off during the burst: each word is a read of the single-port buffer
// memory, then the load of the result register, which waits out any m_tready stall.
// Buffer rows carry valid flags cleared at frame start, so no clearing pass is run after
// reset. Configuration must be written while the block is idle; nothing enforces it.
module ubx_nav_frame_parser_top
    import ubxnav_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 92,
    parameter int FIX_OFFSET    = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [63:0] payload_word, [67:64] word_index
    output logic [TUSER_W-1:0]    m_tuser,   // [1:0] frame_status, [2] overflowed
    output logic                  m_tlast
);

    cmd_t cmd;
    sts_t sts;

    ubxnav_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ubxnav_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FIX_OFFSET    (FIX_OFFSET)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rx_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* src/ubxnav_ctrl.sv */
// Frame parse sequencer and word-burst controller.
module ubxnav_ctrl
    import ubxnav_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_CLASS,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CK_A,
        ST_CK_B,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;

    always_comb
    begin
        unique case (state_reg)
            ST_SYNC1, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI,
            ST_PAYLOAD, ST_CK_A:
                s_tready = 1'b1;
            // the second checksum byte may produce a status result at once
            ST_CK_B:
                s_tready = sts.out_free;
            default:
                s_tready = 1'b0;
        endcase
    end

    assign take = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        cmd.status = STAT_WORD;
        state_next = state_reg;
        unique case (state_reg)
            ST_SYNC1:
            begin
                if (take && sts.is_sync1)
                    state_next = ST_SYNC2;
            end
            ST_SYNC2:
            begin
                if (take)
                    state_next = sts.is_sync2 ? ST_CLASS : ST_SYNC1;
            end
            ST_CLASS:
            begin
                if (take)
                begin
                    cmd.ld_class = 1'b1;
                    cmd.sum_init = 1'b1;
                    state_next   = ST_ID;
                end
            end
            ST_ID:
            begin
                if (take)
                begin
                    cmd.ld_id   = 1'b1;
                    cmd.sum_add = 1'b1;
                    state_next  = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (take)
                begin
                    cmd.ld_len_lo = 1'b1;
                    cmd.sum_add   = 1'b1;
                    state_next    = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (take)
                begin
                    cmd.ld_len_hi = 1'b1;
                    cmd.sum_add   = 1'b1;
                    if (sts.class_match)
                    begin
                        cmd.frame_start = 1'b1;
                        state_next      = sts.len_zero ? ST_CK_A : ST_PAYLOAD;
                    end
                    else
                        state_next = ST_SYNC1;
                end
            end
            ST_PAYLOAD:
            begin
                if (take)
                begin
                    cmd.pay_byte = 1'b1;
                    cmd.sum_add  = 1'b1;
                    if (sts.pay_done)
                        state_next = ST_CK_A;
                end
            end
            ST_CK_A:
            begin
                if (take)
                begin
                    cmd.ld_ck_a = 1'b1;
                    state_next  = ST_CK_B;
                end
            end
            ST_CK_B:
            begin
                if (take)
                begin
                    if (!sts.ck_ok)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = STAT_CKSUM;
                        state_next      = ST_SYNC1;
                    end
                    else if (!sts.fix_ok)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status      = STAT_FIX_LOW;
                        state_next      = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = sts.word_last ? ST_SYNC1 : ST_READ;
                end
            end
            default:
                state_next = ST_SYNC1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SYNC1;
        else
            state_reg <= state_next;
    end

endmodule

/* src/ubxnav_dp.sv */
// Datapath: header fields, Fletcher sums, payload buffer memory and result register.
`include "ubx_nav_frame_parser_top_defines.svh"

module ubxnav_dp
    import ubxnav_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 92,
    parameter int FIX_OFFSET    = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]            cfg_wdata,
    input  logic [7:0]            rx_byte,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [TUSER_W-1:0]    m_tuser,
    output logic                  m_tlast
);

    localparam int          WORD_COUNT  = (PAYLOAD_BYTES + 7) / 8;
    localparam int          WC_W        = $clog2(WORD_COUNT);
    localparam logic [15:0] PAY_LIMIT   = 16'(PAYLOAD_BYTES);
    localparam logic [15:0] LAST_STORED = 16'(PAYLOAD_BYTES - 1);
    localparam logic [15:0] FIX_POS     = 16'(FIX_OFFSET);
    localparam logic [WC_W-1:0] LAST_WORD = WC_W'(WORD_COUNT - 1);

    logic [7:0]            wanted_class_reg;
    logic [7:0]            wanted_id_reg;
    logic [7:0]            min_fix_reg;
    logic [7:0]            frame_class_reg;
    logic [7:0]            frame_id_reg;
    logic [15:0]           len_reg;
    logic [15:0]           count_reg;
    logic [7:0]            sum_a_reg;
    logic [7:0]            sum_b_reg;
    logic [7:0]            ck_a_reg;
    logic                  ovf_reg;
    logic [7:0]            fix_reg;
    logic [WORD_COUNT-1:0] valid_reg;
    logic [WC_W-1:0]       word_cnt_reg;
    logic                  rd_hit_reg;
    logic [63:0]           rd_data_reg;
    logic [63:0]           asm_reg;
    logic [63:0]           mem [WORD_COUNT];

    logic                  out_valid_reg;
    logic [63:0]           out_word_reg;
    logic [3:0]            out_index_reg;
    logic [1:0]            out_status_reg;
    logic                  out_ovf_reg;
    logic                  out_last_reg;

    logic [7:0]            sum_a_next;
    logic [7:0]            sum_b_next;
    logic                  stored;
    logic                  pay_done;
    logic                  flush;
    logic [WC_W-1:0]       row;
    logic [63:0]           asm_fill;
    logic                  out_free;
    logic                  word_last;

    assign sum_a_next = sum_a_reg + rx_byte;
    assign sum_b_next = sum_b_reg + sum_a_next;

    assign stored   = count_reg < PAY_LIMIT;
    assign pay_done = ({1'b0, count_reg} + 17'd1) >= {1'b0, len_reg};
    // a row is written once it is full, at frame end, or at the buffer end
    assign flush    = stored && ((count_reg[2:0] == 3'd7) || pay_done ||
                                 (count_reg == LAST_STORED));
    assign row      = count_reg[WC_W+2:3];

    always_comb
    begin
        asm_fill = asm_reg;
        asm_fill[{count_reg[2:0], 3'b000} +: 8] = rx_byte;
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign word_last = word_cnt_reg == LAST_WORD;

    assign sts.is_sync1    = rx_byte == SYNC_FIRST;
    assign sts.is_sync2    = rx_byte == SYNC_SECOND;
    assign sts.class_match = (frame_class_reg == wanted_class_reg) &&
                             (frame_id_reg == wanted_id_reg);
    assign sts.len_zero    = (rx_byte == 8'h00) && (len_reg[7:0] == 8'h00);
    assign sts.pay_done    = pay_done;
    assign sts.ck_ok       = (ck_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);
    assign sts.fix_ok      = fix_reg >= min_fix_reg;
    assign sts.out_free    = out_free;
    assign sts.word_last   = word_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_class_reg <= 8'd1;
            wanted_id_reg    <= 8'd7;
            min_fix_reg      <= 8'd3;
            frame_class_reg  <= '0;
            frame_id_reg     <= '0;
            len_reg          <= '0;
            count_reg        <= '0;
            sum_a_reg        <= '0;
            sum_b_reg        <= '0;
            ck_a_reg         <= '0;
            ovf_reg          <= 1'b0;
            fix_reg          <= '0;
            valid_reg        <= '0;
            word_cnt_reg     <= '0;
            rd_hit_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_index_reg    <= '0;
            out_status_reg   <= STAT_WORD;
            out_ovf_reg      <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_WANTED_CLASS: wanted_class_reg <= cfg_wdata;
                    CFG_WANTED_ID:    wanted_id_reg    <= cfg_wdata;
                    CFG_MIN_FIX:      min_fix_reg      <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (cmd.sum_init)
            begin
                sum_a_reg <= rx_byte;
                sum_b_reg <= rx_byte;
            end
            else if (cmd.sum_add)
            begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
            end

            if (cmd.ld_class)
                frame_class_reg <= rx_byte;
            if (cmd.ld_id)
                frame_id_reg <= rx_byte;
            if (cmd.ld_len_lo)
                len_reg <= {8'h00, rx_byte};
            if (cmd.ld_len_hi)
                len_reg[15:8] <= rx_byte;
            if (cmd.ld_ck_a)
                ck_a_reg <= rx_byte;

            if (cmd.frame_start)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
                fix_reg   <= '0;
                valid_reg <= '0;
            end
            else if (cmd.pay_byte)
            begin
                count_reg <= count_reg + 16'd1;
                if (!stored)
                    ovf_reg <= 1'b1;
                if (stored && (count_reg == FIX_POS))
                    fix_reg <= rx_byte;
                if (flush)
                    valid_reg[row] <= 1'b1;
            end

            if (cmd.rd_first)
                word_cnt_reg <= '0;
            else if (cmd.emit_word && !word_last)
                word_cnt_reg <= word_cnt_reg + 1'b1;

            if (cmd.rd_issue)
                rd_hit_reg <= valid_reg[word_cnt_reg];

            if (cmd.emit_status)
            begin
                out_valid_reg  <= 1'b1;
                out_index_reg  <= '0;
                out_status_reg <= cmd.status;
                out_ovf_reg    <= ovf_reg;
                out_last_reg   <= 1'b1;
            end
            else if (cmd.emit_word)
            begin
                out_valid_reg  <= 1'b1;
                out_index_reg  <= 4'(word_cnt_reg);
                out_status_reg <= STAT_WORD;
                out_ovf_reg    <= ovf_reg;
                out_last_reg   <= word_last;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // row assembly, buffer memory and result word; no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.frame_start)
            asm_reg <= '0;
        else if (cmd.pay_byte && stored)
            asm_reg <= flush ? 64'd0 : asm_fill;

        if (cmd.pay_byte && flush)
            mem[row] <= asm_fill;

        if (cmd.rd_issue)
            rd_data_reg <= mem[word_cnt_reg];

        if (cmd.emit_status)
            out_word_reg <= '0;
        else if (cmd.emit_word)
            out_word_reg <= rd_hit_reg ? rd_data_reg : 64'd0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'h0, out_index_reg, out_word_reg};
    assign m_tuser  = {out_ovf_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    `UBXNAV_ASSERT(a_no_overwrite, (cmd.emit_word || cmd.emit_status) |-> (!out_valid_reg || m_tready), "result register loaded while a transfer is pending")
    `UBXNAV_ASSERT(a_status_last, (out_valid_reg && out_status_reg != STAT_WORD) |-> (out_last_reg && out_word_reg == 64'd0), "status result not final or not zero")
    `UBXNAV_ASSERT(a_read_range, cmd.rd_issue |-> (word_cnt_reg <= LAST_WORD), "buffer read beyond last row")
    `UBXNAV_ASSERT_NEXT(a_frame_clear, cmd.frame_start, valid_reg == '0 && fix_reg == 8'h00, "buffer not cleared at frame start")

endmodule

/* tb/ubx_nav_frame_parser_top_tb.sv */
// Self-checking testbench for the UBX navigation frame parser top level.
module ubx_nav_frame_parser_top_tb;
    import ubxnav_pkg::*;

    localparam int PAYLOAD_BYTES = 92;
    localparam int FIX_OFFSET    = 20;
    localparam int WORD_COUNT    = (PAYLOAD_BYTES + 7) / 8;
    localparam int STORE_BYTES   = WORD_COUNT * 8;
    localparam int BURST_CYCLES  = 2 * WORD_COUNT + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    localparam int CK_GOOD  = 0;
    localparam int CK_BAD_A = 1;
    localparam int CK_BAD_B = 2;

    localparam int TX_IDLE_PCT[4] = '{0, 66, 0, 8};
    localparam int RX_IDLE_PCT[4] = '{0, 0, 66, 8};

    typedef enum logic [3:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        GET_CLASS,
        GET_ID,
        GET_LEN_LO,
        GET_LEN_HI,
        GET_PAYLOAD,
        GET_CK_A,
        GET_CK_B
    } parse_phase_t;

    typedef struct {
        logic [63:0] word;
        logic [3:0]  idx;
        logic [1:0]  status;
        logic        ovf;
        logic        last;
    } frame_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [7:0]            cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  m_tlast;

    ubx_nav_frame_parser_top #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .FIX_OFFSET   (FIX_OFFSET)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the parser state
    logic [7:0]   cfg_class   = 8'd1;
    logic [7:0]   cfg_id      = 8'd7;
    logic [7:0]   cfg_min_fix = 8'd3;
    parse_phase_t phase       = HUNT_SYNC1;
    logic [7:0]   frm_class   = '0;
    logic [7:0]   frm_id      = '0;
    logic [15:0]  decl_len    = '0;
    logic [15:0]  byte_cnt    = '0;
    logic [7:0]   sum_a       = '0;
    logic [7:0]   sum_b       = '0;
    logic [7:0]   rx_ck_a     = '0;
    logic         ovf_flag    = 1'b0;
    logic [7:0]   store [STORE_BYTES];

    frame_result_t words_due[$];

    int unsigned errors       = 0;
    int unsigned stall_count  = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    logic        hold_token   = 1'b0;
    logic        seen_token   = 1'b0;
    int          hold_left    = 0;

    initial
    begin
        foreach (store[i])
            store[i] = 8'h00;
    end

    task automatic add_to_sum(input logic [7:0] b);
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
    endtask

    task automatic push_status(input logic [1:0] status);
        frame_result_t r;
        r.word   = '0;
        r.idx    = '0;
        r.status = status;
        r.ovf    = ovf_flag;
        r.last   = 1'b1;
        words_due.push_back(r);
    endtask

    // Advances the shadow parser by one accepted byte and queues what it causes
    task automatic track_rx_byte(input logic [7:0] b);
        frame_result_t r;
        logic [7:0]    fix;
        case (phase)
            HUNT_SYNC1:
                if (b == SYNC_FIRST)
                    phase = HUNT_SYNC2;
            HUNT_SYNC2:
                phase = (b == SYNC_SECOND) ? GET_CLASS : HUNT_SYNC1;
            GET_CLASS:
            begin
                frm_class = b;
                sum_a     = '0;
                sum_b     = '0;
                add_to_sum(b);
                phase = GET_ID;
            end
            GET_ID:
            begin
                frm_id = b;
                add_to_sum(b);
                phase = GET_LEN_LO;
            end
            GET_LEN_LO:
            begin
                decl_len = {8'h00, b};
                add_to_sum(b);
                phase = GET_LEN_HI;
            end
            GET_LEN_HI:
            begin
                decl_len[15:8] = b;
                add_to_sum(b);
                if (frm_class == cfg_class && frm_id == cfg_id)
                begin
                    byte_cnt = '0;
                    ovf_flag = 1'b0;
                    foreach (store[i])
                        store[i] = 8'h00;
                    phase = (decl_len == 0) ? GET_CK_A : GET_PAYLOAD;
                end
                else
                    phase = HUNT_SYNC1;
            end
            GET_PAYLOAD:
            begin
                if (byte_cnt < PAYLOAD_BYTES)
                    store[byte_cnt] = b;
                else
                    ovf_flag = 1'b1;
                add_to_sum(b);
                byte_cnt = byte_cnt + 16'd1;
                if (byte_cnt >= decl_len)
                    phase = GET_CK_A;
            end
            GET_CK_A:
            begin
                rx_ck_a = b;
                phase   = GET_CK_B;
            end
            GET_CK_B:
            begin
                fix = (FIX_OFFSET < PAYLOAD_BYTES) ? store[FIX_OFFSET] : 8'h00;
                if (rx_ck_a != sum_a || b != sum_b)
                    push_status(STAT_CKSUM);
                else if (fix < cfg_min_fix)
                    push_status(STAT_FIX_LOW);
                else
                begin
                    for (int k = 0; k < WORD_COUNT; k++)
                    begin
                        for (int j = 0; j < 8; j++)
                            r.word[8*j +: 8] = store[8*k + j];
                        r.idx    = 4'(k);
                        r.status = STAT_WORD;
                        r.ovf    = ovf_flag;
                        r.last   = (k == WORD_COUNT - 1);
                        words_due.push_back(r);
                    end
                end
                phase = HUNT_SYNC1;
            end
            default:
                phase = HUNT_SYNC1;
        endcase
    endtask

    // Offers one byte, waits for the transfer, then maybe leaves a gap.
    // Entered and left just after a rising edge.
    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        track_rx_byte(b);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input int unsigned len, input logic [7:0] fix,
                              input int fill, input int ck_err);
        logic [7:0]  ca;
        logic [7:0]  cb;
        logic [7:0]  b;
        logic [15:0] len16;
        logic [7:0]  hdr [4];
        len16 = 16'(len);
        hdr   = '{cls, id, len16[7:0], len16[15:8]};
        ca    = '0;
        cb    = '0;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        foreach (hdr[i])
        begin
            ca = ca + hdr[i];
            cb = cb + ca;
            send_byte(hdr[i]);
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            if (i == FIX_OFFSET)
                b = fix;
            ca = ca + b;
            cb = cb + ca;
            send_byte(b);
        end
        if (ck_err == CK_BAD_A)
            ca = ca ^ (8'h01 << $urandom_range(7));
        if (ck_err == CK_BAD_B)
            cb = cb ^ (8'h01 << $urandom_range(7));
        send_byte(ca);
        send_byte(cb);
    endtask

    // Sender stops until every queued result is out and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (BURST_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_WANTED_CLASS: cfg_class   = val;
            CFG_WANTED_ID:    cfg_id      = val;
            CFG_MIN_FIX:      cfg_min_fix = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_idle(input int mode);
        tx_idle_pct = TX_IDLE_PCT[mode];
        rx_idle_pct = RX_IDLE_PCT[mode];
    endtask

    task automatic test_sync_recovery();
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // a repeated first sync does not re-arm the second
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // empty payload: fix type reads as zero, so a low-fix status follows
        send_frame(8'd1, 8'd7, 0, 8'd0, FILL_RANDOM, CK_GOOD);
    endtask

    task automatic test_frame_filter();
        send_frame(8'd2, 8'd7, 0, 8'd0, FILL_RANDOM, CK_GOOD);
        send_frame(8'd1, 8'd8, 0, 8'd0, FILL_RANDOM, CK_GOOD);
    endtask

    task automatic test_checksum_errors();
        send_frame(8'd1, 8'd7, 0, 8'd0, FILL_RANDOM, CK_BAD_A);
        send_frame(8'd1, 8'd7, 0, 8'd0, FILL_RANDOM, CK_BAD_B);
    endtask

    // One byte past the buffer: published words carry the overflow flag
    task automatic test_long_payload();
        send_frame(8'd1, 8'd7, PAYLOAD_BYTES + 1, 8'd9, FILL_RANDOM, CK_GOOD);
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(CFG_WANTED_CLASS, 8'h00);
        write_reg(CFG_WANTED_ID, 8'hFF);
        write_reg(CFG_MIN_FIX, 8'h00);
        send_frame(8'h00, 8'hFF, 0, 8'd0, FILL_RANDOM, CK_GOOD);
        drain();
        write_reg(CFG_WANTED_CLASS, 8'hFF);
        write_reg(CFG_WANTED_ID, 8'h00);
        write_reg(CFG_MIN_FIX, 8'hFF);
        send_frame(8'hFF, 8'h00, 0, 8'd0, FILL_RANDOM, CK_GOOD);
        drain();
        write_reg(CFG_WANTED_CLASS, 8'd1);
        write_reg(CFG_WANTED_ID, 8'd7);
        write_reg(CFG_MIN_FIX, 8'd3);
    endtask

    // Receiver holds off while frames keep arriving, so the input backs up
    task automatic test_backpressure();
        drain();
        write_reg(CFG_MIN_FIX, 8'h00);
        set_idle(0);
        hold_token <= ~hold_token;
        send_frame(cfg_class, cfg_id, 10, 8'd0, FILL_ONES, CK_GOOD);
        send_frame(cfg_class, cfg_id, 0, 8'd0, FILL_RANDOM, CK_GOOD);
        drain();
        write_reg(CFG_MIN_FIX, 8'd3);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            seen_token <= 1'b0;
        end
        else if (hold_token != seen_token)
        begin
            seen_token <= hold_token;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        frame_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (words_due.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata %h tuser %h",
                       m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_r = words_due.pop_front();
                if (m_tdata[63:0] !== exp_r.word)
                begin
                    $error("payload_word: expected %h, actual %h", exp_r.word, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[67:64] !== exp_r.idx)
                begin
                    $error("word_index: expected %0d, actual %0d", exp_r.idx, m_tdata[67:64]);
                    errors++;
                end
                if (m_tuser[1:0] !== exp_r.status)
                begin
                    $error("frame_status: expected %0d, actual %0d", exp_r.status, m_tuser[1:0]);
                    errors++;
                end
                if (m_tuser[2] !== exp_r.ovf)
                begin
                    $error("overflowed: expected %0d, actual %0d", exp_r.ovf, m_tuser[2]);
                    errors++;
                end
                if (m_tlast !== exp_r.last)
                begin
                    $error("last_word: expected %0d, actual %0d", exp_r.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("ubx_nav_frame_parser_top_tb failed");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(0);
        test_sync_recovery();
        set_idle(1);
        test_frame_filter();
        test_checksum_errors();
        set_idle(2);
        test_long_payload();
        set_idle(3);
        test_config_extremes();
        test_backpressure();
        drain();
        if (words_due.size() != 0)
        begin
            $error("%0d expected results never arrived", words_due.size());
            errors++;
        end
        if (errors == 0)
            $display("ubx_nav_frame_parser_top_tb passed");
        else
            $display("ubx_nav_frame_parser_top_tb failed");
        $finish;
    end

endmodule
